// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the range-minimum engine RTL.
// No dependencies; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that prop holds at every clock edge outside reset.
`define RMST_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rmst assertion failed");
// Check that cond is never true outside reset.
`define RMST_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rmst assertion failed");
`else
`define RMST_ASSERT(name, clk, rst_n, prop)
`define RMST_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ===== rtl/core/rmst_pkg.sv =====
// Shared types and constants of the range-minimum segment tree engine.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package rmst_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int VALUE_WIDTH  = 32;
  localparam int INDEX_WIDTH  = $clog2(MAX_ELEMENTS);
  localparam int COUNT_WIDTH  = INDEX_WIDTH + 1;
  localparam int NODE_WIDTH   = INDEX_WIDTH + 1;
  localparam int TREE_NODES   = 2 * MAX_ELEMENTS;
  // One saved parent per tree level below the root
  localparam int STACK_DEPTH  = INDEX_WIDTH;
  localparam int STACK_AW     = $clog2(STACK_DEPTH);
  localparam int SP_WIDTH     = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VISIT,
    ST_LEAF_RD,
    ST_TREE_RD,
    ST_ELEM_RD,
    ST_RETURN,
    ST_RESUME
  } state_e;

  typedef struct packed {
    logic load_elem;
    logic init_root;
    logic descend;
    logic ret_miss;
    logic tree_wr_leaf;
    logic elem_rd_leaf;
    logic ret_leaf;
    logic tree_rd;
    logic elem_rd_tree;
    logic ret_cover;
    logic pop;
    logic resume_left;
    logic resume_right;
    logic tree_wr_comb;
    logic emit_hit;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    logic range_empty;
    logic is_leaf;
    logic disjoint;
    logic covered;
    logic stack_empty;
    logic on_right;
  } status_t;

  typedef struct packed {
    logic [NODE_WIDTH-1:0]         node;
    logic [INDEX_WIDTH-1:0]        s;
    logic [INDEX_WIDTH-1:0]        e;
    logic                          on_right;
    logic                          lhit;
    logic [INDEX_WIDTH-1:0]        lidx;
    logic signed [VALUE_WIDTH-1:0] lval;
  } frame_t;

endpackage

`default_nettype wire

// ===== rtl/core/range_minimum_segment_tree.sv =====
// Top level of the range-minimum segment tree engine.
// Depends on rmst_pkg, rmst_ctrl and rmst_datapath.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-------------------------------------
//   command  | start / busy                 | opcode, element_index, element_value,
//            |                              | range_low, range_high
//   result   | done_o strobe, one cycle     | found, min_index, min_value
//   config   | element_count_we_i           | element_count_i
//
// A load does not raise busy. A build walks every node depth first. A query
// descends only into nodes that the range meets but does not cover, and visits
// at most four nodes per level. Cost is set by the single read port of each
// memory and the one-frame-a-cycle stack.
// Reset clears the sequencer, stack pointer and strobe; memories are not cleared.
// A result shows for one cycle after the transfer that ends the query.
`default_nettype none

module range_minimum_segment_tree import rmst_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [INDEX_WIDTH-1:0]        element_index_i,
  input  wire logic signed [VALUE_WIDTH-1:0] element_value_i,
  input  wire logic [INDEX_WIDTH-1:0]        range_low_i,
  input  wire logic [INDEX_WIDTH-1:0]        range_high_i,
  input  wire logic                          element_count_we_i,
  input  wire logic [COUNT_WIDTH-1:0]        element_count_i,
  output logic                               done_o,
  output logic                               found_o,
  output logic [INDEX_WIDTH-1:0]             min_index_o,
  output logic signed [VALUE_WIDTH-1:0]      min_value_o
);

  cmd_t    cmd;
  status_t status;

  rmst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  rmst_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .element_count_we_i (element_count_we_i),
    .element_count_i    (element_count_i),
    .element_index_i    (element_index_i),
    .element_value_i    (element_value_i),
    .range_low_i        (range_low_i),
    .range_high_i       (range_high_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .done_o             (done_o),
    .found_o            (found_o),
    .min_index_o        (min_index_o),
    .min_value_o        (min_value_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rmst_ctrl.sv =====
// Sequencer of the range-minimum engine: walks the tree depth first for
// build and query. Depends on rmst_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rmst_ctrl import rmst_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] opcode_i,
  input  wire status_t    status_i,
  output cmd_t            cmd_o,
  output logic            busy_o
);

  state_e state_q, state_d;
  logic   query_q, query_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      query_q <= 1'b0;
    end else begin
      state_q <= state_d;
      query_q <= query_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    query_d = query_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (opcode_e'(opcode_i))
            OP_BUILD: begin
              query_d = 1'b0;
              state_d = ST_VISIT;
            end
            OP_QUERY: begin
              if (!status_i.range_empty) begin
                query_d = 1'b1;
                state_d = ST_VISIT;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_VISIT: begin
        if (!query_q) begin
          state_d = status_i.is_leaf ? ST_LEAF_RD : ST_VISIT;
        end else if (status_i.disjoint) begin
          state_d = ST_RETURN;
        end else if (status_i.covered) begin
          state_d = ST_TREE_RD;
        end else if (status_i.is_leaf) begin
          state_d = ST_RETURN;
        end else begin
          state_d = ST_VISIT;
        end
      end
      ST_LEAF_RD: state_d = ST_RETURN;
      ST_TREE_RD: state_d = ST_ELEM_RD;
      ST_ELEM_RD: state_d = ST_RETURN;
      ST_RETURN:  state_d = status_i.stack_empty ? ST_IDLE : ST_RESUME;
      ST_RESUME:  state_d = status_i.on_right ? ST_RETURN : ST_VISIT;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (opcode_e'(opcode_i))
            OP_LOAD:  cmd_o.load_elem = 1'b1;
            OP_BUILD: cmd_o.init_root = 1'b1;
            OP_QUERY: begin
              if (status_i.range_empty) begin
                cmd_o.emit_empty = 1'b1;
              end else begin
                cmd_o.init_root = 1'b1;
              end
            end
            default: cmd_o = '0;
          endcase
        end
      end
      ST_VISIT: begin
        if (!query_q) begin
          if (status_i.is_leaf) begin
            cmd_o.tree_wr_leaf = 1'b1;
            cmd_o.elem_rd_leaf = 1'b1;
          end else begin
            cmd_o.descend = 1'b1;
          end
        end else if (status_i.disjoint) begin
          cmd_o.ret_miss = 1'b1;
        end else if (status_i.covered) begin
          cmd_o.tree_rd = 1'b1;
        end else if (status_i.is_leaf) begin
          cmd_o.ret_miss = 1'b1;
        end else begin
          cmd_o.descend = 1'b1;
        end
      end
      ST_LEAF_RD: cmd_o.ret_leaf = 1'b1;
      ST_TREE_RD: cmd_o.elem_rd_tree = 1'b1;
      ST_ELEM_RD: cmd_o.ret_cover = 1'b1;
      ST_RETURN: begin
        if (status_i.stack_empty) begin
          cmd_o.emit_hit = query_q;
        end else begin
          cmd_o.pop = 1'b1;
        end
      end
      ST_RESUME: begin
        if (status_i.on_right) begin
          cmd_o.resume_right = 1'b1;
          cmd_o.tree_wr_comb = !query_q;
        end else begin
          cmd_o.resume_left = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  `RMST_ASSERT(a_emit_at_root, clk_i, rst_ni, cmd_o.emit_hit |-> status_i.stack_empty)
  `RMST_ASSERT_NEVER(a_tree_wr_in_query, clk_i, rst_ni, query_q && (cmd_o.tree_wr_leaf || cmd_o.tree_wr_comb))
  `RMST_ASSERT(a_load_when_idle, clk_i, rst_ni, cmd_o.load_elem |-> !busy_o)

endmodule

`default_nettype wire

// ===== rtl/core/rmst_datapath.sv =====
// Datapath of the range-minimum engine: element and tree memories, call
// stack, current frame, return register and result registers.
// Depends on rmst_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rmst_datapath import rmst_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          element_count_we_i,
  input  wire logic [COUNT_WIDTH-1:0]        element_count_i,
  input  wire logic [INDEX_WIDTH-1:0]        element_index_i,
  input  wire logic signed [VALUE_WIDTH-1:0] element_value_i,
  input  wire logic [INDEX_WIDTH-1:0]        range_low_i,
  input  wire logic [INDEX_WIDTH-1:0]        range_high_i,
  input  wire cmd_t                          cmd_i,
  output status_t                            status_o,
  output logic                               done_o,
  output logic                               found_o,
  output logic [INDEX_WIDTH-1:0]             min_index_o,
  output logic signed [VALUE_WIDTH-1:0]      min_value_o
);

  logic signed [VALUE_WIDTH-1:0] elem_mem [MAX_ELEMENTS];
  logic [INDEX_WIDTH-1:0]        tree_mem [TREE_NODES];
  frame_t                        stack_q  [STACK_DEPTH];

  logic [COUNT_WIDTH-1:0]        count_q;
  logic [SP_WIDTH-1:0]           sp_q;
  logic [SP_WIDTH-1:0]           sp_m1;
  frame_t                        cur_q;
  frame_t                        push_frame;
  logic [INDEX_WIDTH-1:0]        lo_q, hi_q;
  logic                          ret_hit_q;
  logic [INDEX_WIDTH-1:0]        ret_idx_q;
  logic signed [VALUE_WIDTH-1:0] ret_val_q;
  logic signed [VALUE_WIDTH-1:0] elem_rd_q;
  logic [INDEX_WIDTH-1:0]        tree_rd_q;
  logic                          done_q, found_q;
  logic [INDEX_WIDTH-1:0]        min_index_q;
  logic signed [VALUE_WIDTH-1:0] min_value_q;

  logic [COUNT_WIDTH-1:0]        count_eff;
  logic [COUNT_WIDTH-1:0]        count_m1;
  logic [INDEX_WIDTH-1:0]        last_idx;
  logic [INDEX_WIDTH-1:0]        hi_clip;
  logic [COUNT_WIDTH-1:0]        span_sum;
  logic [INDEX_WIDTH-1:0]        mid;
  logic [NODE_WIDTH-1:0]         left_node, right_node;
  logic                          left_wins;
  logic [INDEX_WIDTH-1:0]        elem_rd_addr;
  logic [INDEX_WIDTH-1:0]        tree_wr_data;

  // Count of zero acts as one, anything past the store acts as full
  always_comb begin
    if (count_q == '0) begin
      count_eff = COUNT_WIDTH'(1);
    end else if (count_q > COUNT_WIDTH'(MAX_ELEMENTS)) begin
      count_eff = COUNT_WIDTH'(MAX_ELEMENTS);
    end else begin
      count_eff = count_q;
    end
  end

  assign count_m1 = count_eff - 1'b1;
  assign last_idx = count_m1[INDEX_WIDTH-1:0];
  assign hi_clip  = (range_high_i > last_idx) ? last_idx : range_high_i;

  assign span_sum   = {1'b0, cur_q.s} + {1'b0, cur_q.e};
  assign mid        = span_sum[COUNT_WIDTH-1:1];
  assign left_node  = {cur_q.node[NODE_WIDTH-2:0], 1'b0};
  assign right_node = {cur_q.node[NODE_WIDTH-2:0], 1'b1};
  assign sp_m1      = sp_q - 1'b1;

  // Lower index wins ties: left keeps the node unless right is strictly smaller
  assign left_wins = cur_q.lhit && (!ret_hit_q || (cur_q.lval <= ret_val_q));

  always_comb begin
    push_frame = cur_q;
    if (cmd_i.resume_left) begin
      push_frame.on_right = 1'b1;
      push_frame.lhit     = ret_hit_q;
      push_frame.lidx     = ret_idx_q;
      push_frame.lval     = ret_val_q;
    end else begin
      push_frame.on_right = 1'b0;
    end
  end

  assign status_o.range_empty = (range_low_i > range_high_i)
                              || ({1'b0, range_low_i} >= count_eff);
  assign status_o.is_leaf     = (cur_q.s == cur_q.e);
  assign status_o.disjoint    = (lo_q > cur_q.e) || (hi_q < cur_q.s);
  assign status_o.covered     = (cur_q.s >= lo_q) && (cur_q.e <= hi_q);
  assign status_o.stack_empty = (sp_q == '0);
  assign status_o.on_right    = cur_q.on_right;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_WIDTH'(1);
      sp_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      if (element_count_we_i) begin
        count_q <= element_count_i;
      end
      if (cmd_i.init_root) begin
        sp_q <= '0;
      end else if (cmd_i.descend || cmd_i.resume_left) begin
        sp_q <= sp_q + 1'b1;
      end else if (cmd_i.pop) begin
        sp_q <= sp_m1;
      end
      done_q <= cmd_i.emit_hit || cmd_i.emit_empty;
    end
  end

  // Frame, stack and return registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_root) begin
      cur_q.node <= NODE_WIDTH'(1);
      cur_q.s    <= '0;
      cur_q.e    <= last_idx;
      lo_q       <= range_low_i;
      hi_q       <= hi_clip;
    end else if (cmd_i.descend) begin
      stack_q[sp_q[STACK_AW-1:0]] <= push_frame;
      cur_q.node <= left_node;
      cur_q.e    <= mid;
    end else if (cmd_i.resume_left) begin
      stack_q[sp_q[STACK_AW-1:0]] <= push_frame;
      cur_q.node <= right_node;
      cur_q.s    <= mid + 1'b1;
    end else if (cmd_i.pop) begin
      cur_q <= stack_q[sp_m1[STACK_AW-1:0]];
    end

    if (cmd_i.ret_miss) begin
      ret_hit_q <= 1'b0;
    end else if (cmd_i.ret_leaf) begin
      ret_hit_q <= 1'b1;
      ret_idx_q <= cur_q.s;
      ret_val_q <= elem_rd_q;
    end else if (cmd_i.ret_cover) begin
      ret_hit_q <= 1'b1;
      ret_idx_q <= tree_rd_q;
      ret_val_q <= elem_rd_q;
    end else if (cmd_i.resume_right) begin
      ret_hit_q <= cur_q.lhit || ret_hit_q;
      if (left_wins) begin
        ret_idx_q <= cur_q.lidx;
        ret_val_q <= cur_q.lval;
      end
    end

    if (cmd_i.emit_hit) begin
      found_q     <= ret_hit_q;
      min_index_q <= ret_hit_q ? ret_idx_q : '0;
      min_value_q <= ret_hit_q ? ret_val_q : '0;
    end else if (cmd_i.emit_empty) begin
      found_q     <= 1'b0;
      min_index_q <= '0;
      min_value_q <= '0;
    end
  end

  // Element store: one write port, one registered read port
  assign elem_rd_addr = cmd_i.elem_rd_tree ? tree_rd_q : cur_q.s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_elem) begin
      elem_mem[element_index_i] <= element_value_i;
    end
    if (cmd_i.elem_rd_leaf || cmd_i.elem_rd_tree) begin
      elem_rd_q <= elem_mem[elem_rd_addr];
    end
  end

  // Tree store: node holds the index of its span's minimum
  assign tree_wr_data = cmd_i.tree_wr_comb ? (left_wins ? cur_q.lidx : ret_idx_q) : cur_q.s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tree_wr_leaf || cmd_i.tree_wr_comb) begin
      tree_mem[cur_q.node] <= tree_wr_data;
    end
    if (cmd_i.tree_rd) begin
      tree_rd_q <= tree_mem[cur_q.node];
    end
  end

  assign done_o      = done_q;
  assign found_o     = found_q;
  assign min_index_o = min_index_q;
  assign min_value_o = min_value_q;

  `RMST_ASSERT(a_no_overflow, clk_i, rst_ni, (cmd_i.descend || cmd_i.resume_left) |-> (sp_q < SP_WIDTH'(STACK_DEPTH)))
  `RMST_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, cmd_i.pop && (sp_q == '0))
  `RMST_ASSERT(a_descend_internal, clk_i, rst_ni, cmd_i.descend |-> (cur_q.s != cur_q.e))

endmodule

`default_nettype wire

// ===== tb/sv/tb_range_minimum_segment_tree.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for range_minimum_segment_tree: drives element loads,
// tree builds and range-minimum queries; query answers are checked against a behavioral tree.
// Depends on rmst_pkg and the range_minimum_segment_tree RTL.

module tb_range_minimum_segment_tree;
  import rmst_pkg::*;

  localparam int LIMIT_CYCLES   = 2_000_000;
  localparam int RAND_PER_PHASE = 40;
  localparam int PRED_NODES     = 4 * MAX_ELEMENTS;
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic                          found;
    logic [INDEX_WIDTH-1:0]        index;
    logic signed [VALUE_WIDTH-1:0] value;
  } minimum_t;

  // Behavioral segment tree plus the queue of query answers still owed.
  class min_query_checker;
    logic signed [VALUE_WIDTH-1:0] elem_val [MAX_ELEMENTS];
    logic [INDEX_WIDTH-1:0]        node_min [PRED_NODES];
    logic [COUNT_WIDTH-1:0]        count_reg;
    minimum_t                      pending_minima [$];
    int unsigned                   mismatches;
    int unsigned                   checked;

    function new();
      foreach (elem_val[i]) elem_val[i] = '0;
      foreach (node_min[i]) node_min[i] = '0;
      count_reg = COUNT_WIDTH'(1);
      mismatches = 0;
      checked = 0;
    endfunction

    function int span();
      if (count_reg == 0) return 1;
      if (count_reg > MAX_ELEMENTS) return MAX_ELEMENTS;
      return count_reg;
    endfunction

    // Lower index wins unless the right value is strictly smaller.
    function int lower(int a, int b);
      return (elem_val[a] <= elem_val[b]) ? a : b;
    endfunction

    function void build_span(int node, int s, int e);
      int mid;
      if (node >= PRED_NODES) return;
      if (s == e) begin
        node_min[node] = INDEX_WIDTH'(s);
        return;
      end
      mid = (s + e) / 2;
      build_span(2 * node, s, mid);
      build_span(2 * node + 1, mid + 1, e);
      if (2 * node + 1 < PRED_NODES)
        node_min[node] = INDEX_WIDTH'(lower(node_min[2 * node], node_min[2 * node + 1]));
    endfunction

    function bit search_span(int node, int s, int e, int lo, int hi, output int pos);
      int mid;
      int pl;
      int pr;
      bit hl;
      bit hr;
      pos = 0;
      pl = 0;
      pr = 0;
      if (lo > e || hi < s || node >= PRED_NODES) return 0;
      if (s >= lo && e <= hi) begin
        pos = node_min[node];
        return 1;
      end
      if (s == e) return 0;
      mid = (s + e) / 2;
      hl = search_span(2 * node, s, mid, lo, hi, pl);
      hr = search_span(2 * node + 1, mid + 1, e, lo, hi, pr);
      if (!hl && !hr) return 0;
      if (!hl) pos = pr;
      else if (!hr) pos = pl;
      else pos = lower(pl, pr);
      return 1;
    endfunction

    function void note_item(opcode_e op, int unsigned idx, logic signed [VALUE_WIDTH-1:0] val,
                            int lo, int hi);
      minimum_t m;
      int n;
      int pos;
      int top;
      n = span();
      case (op)
        OP_LOAD: elem_val[idx] = val;
        OP_BUILD: build_span(1, 0, n - 1);
        OP_QUERY: begin
          m = '0;
          top = hi;
          if (lo <= hi && lo < n) begin
            if (top > n - 1) top = n - 1;
            if (search_span(1, 0, n - 1, lo, top, pos)) begin
              m.found = 1'b1;
              m.index = INDEX_WIDTH'(pos);
              m.value = elem_val[pos];
            end
          end
          pending_minima.push_back(m);
        end
        default: ;
      endcase
    endfunction

    function void check(logic f, logic [INDEX_WIDTH-1:0] i, logic signed [VALUE_WIDTH-1:0] v);
      minimum_t want;
      if (pending_minima.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no query outstanding: found=%0b index=%0d value=%0d",
                   $realtime, f, i, v);
        return;
      end
      want = pending_minima.pop_front();
      checked++;
      if (f !== want.found || i !== want.index || v !== want.value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: query mismatch: expected found=%0b index=%0d value=%0d, got found=%0b index=%0d value=%0d",
                   $realtime, want.found, want.index, want.value, f, i, v);
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic [1:0]                    opcode_i;
  logic [INDEX_WIDTH-1:0]        element_index_i;
  logic signed [VALUE_WIDTH-1:0] element_value_i;
  logic [INDEX_WIDTH-1:0]        range_low_i;
  logic [INDEX_WIDTH-1:0]        range_high_i;
  logic                          element_count_we_i;
  logic [COUNT_WIDTH-1:0]        element_count_i;
  logic                          done_o;
  logic                          found_o;
  logic [INDEX_WIDTH-1:0]        min_index_o;
  logic signed [VALUE_WIDTH-1:0] min_value_o;

  min_query_checker sb;
  bit          loaded [MAX_ELEMENTS];
  bit          gaps_on;
  int unsigned cycles = 0;
  int unsigned loads_sent = 0;
  int unsigned builds_sent = 0;
  int unsigned nops_sent = 0;
  int unsigned settings = 0;

  range_minimum_segment_tree DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode_i),
    .element_index_i    (element_index_i),
    .element_value_i    (element_value_i),
    .range_low_i        (range_low_i),
    .range_high_i       (range_high_i),
    .element_count_we_i (element_count_we_i),
    .element_count_i    (element_count_i),
    .done_o             (done_o),
    .found_o            (found_o),
    .min_index_o        (min_index_o),
    .min_value_o        (min_value_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("range_minimum_segment_tree test failed");
      $finish;
    end
  end

  // Results cannot be held off: take every strobe as it comes.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1)
      sb.check(found_o, min_index_o, min_value_o);
  end

  function automatic logic signed [VALUE_WIDTH-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return VALUE_MIN;
      1: return VALUE_MAX;
      2, 3: return VALUE_WIDTH'(int'($urandom_range(0, 4)) - 2);
      default: return $urandom;
    endcase
  endfunction

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 15)) @(posedge clk_i);
  endtask

  // Hold start and the fields until the transfer, then note it.
  task automatic send_item(opcode_e op, int unsigned idx, logic signed [VALUE_WIDTH-1:0] val,
                           int unsigned lo, int unsigned hi);
    start <= 1'b1;
    opcode_i <= op;
    element_index_i <= idx[INDEX_WIDTH-1:0];
    element_value_i <= val;
    range_low_i <= lo[INDEX_WIDTH-1:0];
    range_high_i <= hi[INDEX_WIDTH-1:0];
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    sb.note_item(op, idx, val, lo, hi);
    case (op)
      OP_LOAD: begin
        loaded[idx] = 1'b1;
        loads_sent++;
      end
      OP_BUILD: builds_sent++;
      OP_NOP: nops_sent++;
      default: ;
    endcase
    if (gaps_on && $urandom_range(0, 2) == 0) idle_burst();
  endtask

  task automatic query(int unsigned lo, int unsigned hi);
    send_item(OP_QUERY, $urandom_range(0, MAX_ELEMENTS - 1), rand_value(), lo, hi);
  endtask

  // Drain: no answers owed, then allow a full build to finish.
  task automatic settle();
    start <= 1'b0;
    while (sb.pending_minima.size() != 0) @(posedge clk_i);
    repeat (8 * sb.span() + 32) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic set_count(int unsigned c);
    settle();
    element_count_we_i <= 1'b1;
    element_count_i <= c[COUNT_WIDTH-1:0];
    @(posedge clk_i);
    sb.count_reg = c[COUNT_WIDTH-1:0];
    settings++;
    element_count_we_i <= 1'b0;
  endtask

  task automatic random_item(int n);
    int unsigned roll;
    int unsigned lo;
    int unsigned hi;
    int unsigned idx;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      case ($urandom_range(0, 9))
        6: begin
          lo = $urandom_range(0, MAX_ELEMENTS - 1);
          hi = $urandom_range(0, MAX_ELEMENTS - 1);
        end
        7: begin
          lo = $urandom_range(1, MAX_ELEMENTS - 1);
          hi = $urandom_range(0, lo - 1);
        end
        8: begin
          lo = $urandom_range(0, n - 1);
          hi = $urandom_range(n - 1, MAX_ELEMENTS - 1);
        end
        9: begin
          lo = (n < MAX_ELEMENTS) ? $urandom_range(n, MAX_ELEMENTS - 1)
                                  : $urandom_range(0, MAX_ELEMENTS - 1);
          hi = $urandom_range(lo, MAX_ELEMENTS - 1);
        end
        default: begin
          lo = $urandom_range(0, n - 1);
          hi = $urandom_range(lo, n - 1);
        end
      endcase
      query(lo, hi);
    end else if (roll < 82) begin
      idx = $urandom_range(0, 1) ? $urandom_range(0, n - 1) : $urandom_range(0, MAX_ELEMENTS - 1);
      send_item(OP_LOAD, idx, rand_value(), $urandom_range(0, MAX_ELEMENTS - 1),
                $urandom_range(0, MAX_ELEMENTS - 1));
    end else if (roll < 92) begin
      send_item(OP_BUILD, $urandom_range(0, MAX_ELEMENTS - 1), rand_value(),
                $urandom_range(0, MAX_ELEMENTS - 1), $urandom_range(0, MAX_ELEMENTS - 1));
    end else begin
      send_item(OP_NOP, $urandom_range(0, MAX_ELEMENTS - 1), rand_value(),
                $urandom_range(0, MAX_ELEMENTS - 1), $urandom_range(0, MAX_ELEMENTS - 1));
    end
  endtask

  // Every element in use must hold a value before the tree is built.
  task automatic run_phase(int unsigned c, bit gaps);
    int n;
    set_count(c);
    gaps_on = gaps;
    n = sb.span();
    for (int i = 0; i < n; i++) begin
      if (!loaded[i] || n <= 128) send_item(OP_LOAD, i, rand_value(), 0, 0);
    end
    send_item(OP_BUILD, 0, '0, 0, 0);
    repeat (RAND_PER_PHASE) random_item(n);
  endtask

  initial begin
    sb = new();
    rst_ni <= 1'b0;
    start <= 1'b0;
    opcode_i <= OP_NOP;
    element_index_i <= '0;
    element_value_i <= '0;
    range_low_i <= '0;
    range_high_i <= '0;
    element_count_we_i <= 1'b0;
    element_count_i <= '0;
    gaps_on = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset count of one: single element, clipped and empty ranges
    send_item(OP_LOAD, 0, VALUE_MAX, 0, 0);
    send_item(OP_BUILD, 0, '0, 0, 0);
    query(0, 0);
    query(0, MAX_ELEMENTS - 1);
    query(1, MAX_ELEMENTS - 1);

    // Eight elements with both extremes and a tie across the two halves
    set_count(8);
    send_item(OP_LOAD, 0, 7, 0, 0);
    send_item(OP_LOAD, 1, VALUE_MAX, 0, 0);
    send_item(OP_LOAD, 2, -3, 0, 0);
    send_item(OP_LOAD, 3, 0, 0, 0);
    send_item(OP_LOAD, 4, VALUE_MAX, 0, 0);
    send_item(OP_LOAD, 5, -3, 0, 0);
    send_item(OP_LOAD, 6, -1, 0, 0);
    send_item(OP_LOAD, 7, VALUE_MIN, 0, 0);
    send_item(OP_LOAD, MAX_ELEMENTS - 1, -5, 0, 0);
    send_item(OP_BUILD, 0, '0, 0, 0);
    query(0, 6);
    query(0, MAX_ELEMENTS - 1);
    query(6, 2);
    query(8, MAX_ELEMENTS - 1);
    query(1, 1);
    send_item(OP_NOP, MAX_ELEMENTS - 1, VALUE_MIN, MAX_ELEMENTS - 1, MAX_ELEMENTS - 1);
    // Load without rebuild: the tree stays stale
    send_item(OP_LOAD, 0, -100, 0, 0);
    query(0, 7);
    query(0, 1);

    run_phase(0, 1'b1);
    run_phase(37, 1'b1);
    run_phase(MAX_ELEMENTS, 1'b1);
    run_phase(2, 1'b0);
    run_phase(MAX_ELEMENTS + 1, 1'b1);
    run_phase(100, 1'b1);
    run_phase(2 ** COUNT_WIDTH - 1, 1'b1);
    run_phase(5, 1'b0);
    run_phase(13, 1'b0);
    run_phase(64, 1'b0);

    settle();
    $display("Covered %0d query answers, %0d loads, %0d builds, %0d idle opcodes",
             sb.checked, loads_sent, builds_sent, nops_sent);
    $display("over %0d element_count settings, including 0, 1024, 1025 and 2047.", settings);
    if (sb.mismatches == 0 && sb.pending_minima.size() == 0) begin
      $display("range_minimum_segment_tree test passed");
    end else begin
      $display("%0d mismatches, %0d query answers never arrived",
               sb.mismatches, sb.pending_minima.size());
      $display("range_minimum_segment_tree test failed");
    end
    $finish;
  end

endmodule
